/* src/chroma_upsample_yuv_to_rgb_macros.svh */
// ----------------------------------------------------------------------------
// chroma_upsample_yuv_to_rgb assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef CHROMA_UPSAMPLE_YUV_TO_RGB_MACROS_SVH
`define CHROMA_UPSAMPLE_YUV_TO_RGB_MACROS_SVH

// property checked on rising clock, masked while reset is asserted
`define CUS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// property checked on every rising clock, reset included
`define CUS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/cus_pkg.sv */
// ----------------------------------------------------------------------------
// cus_pkg
// Types and constants shared by the chroma upsampler and color converter.
// ----------------------------------------------------------------------------
package cus_pkg;

    localparam int SAMPLE_W = 12;
    localparam int COORD_W  = 16;
    localparam int DEPTH_W  = 4;
    localparam int CFG_IDX_W = 2;
    localparam int SCALE_W  = 17;
    localparam int BYTE_W   = 8;

    // vertical chroma weighting of the top and bottom rows
    typedef enum logic [1:0] {
        VW_TOP     = 2'd0,   // top row as is
        VW_HALF    = 2'd1,   // (t + b + 1) >> 1
        VW_QUARTER = 2'd2,   // (3t + b + 2) >> 2
        VW_3QUART  = 2'd3    // (t + 3b + 2) >> 2
    } t_vmode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLE_DEPTH = 2'd0,
        CFG_SUB_HORIZ    = 2'd1,
        CFG_SUB_VERT     = 2'd2,
        CFG_VERT_SITING  = 2'd3
    } t_cfg_idx;

    // normalization 255 / (2^d - 1) in Q1.16, rounded
    localparam int unsigned FULL_SCALE = 255 * 65536;
    localparam int unsigned DEN_8  = (1 << 8) - 1;
    localparam int unsigned DEN_9  = (1 << 9) - 1;
    localparam int unsigned DEN_10 = (1 << 10) - 1;
    localparam int unsigned DEN_11 = (1 << 11) - 1;
    localparam int unsigned DEN_12 = (1 << 12) - 1;
    localparam logic [SCALE_W-1:0] SCALE_8  = SCALE_W'((FULL_SCALE + DEN_8 / 2) / DEN_8);
    localparam logic [SCALE_W-1:0] SCALE_9  = SCALE_W'((FULL_SCALE + DEN_9 / 2) / DEN_9);
    localparam logic [SCALE_W-1:0] SCALE_10 = SCALE_W'((FULL_SCALE + DEN_10 / 2) / DEN_10);
    localparam logic [SCALE_W-1:0] SCALE_11 = SCALE_W'((FULL_SCALE + DEN_11 / 2) / DEN_11);
    localparam logic [SCALE_W-1:0] SCALE_12 = SCALE_W'((FULL_SCALE + DEN_12 / 2) / DEN_12);

    // 127.5 in Q8.16
    localparam logic signed [29:0] HALF_OFFSET = 30'sd8355840;

    // Q4.14 matrix coefficients (signed, 18 bits)
    localparam logic signed [17:0] COEF_RV = 18'sd18675;
    localparam logic signed [17:0] COEF_GU = 18'sd6466;
    localparam logic signed [17:0] COEF_GV = 18'sd9513;
    localparam logic signed [17:0] COEF_BU = 18'sd33294;

endpackage

/* src/cus_row_weight.sv */
// ----------------------------------------------------------------------------
// cus_row_weight
// Rounded vertical blend of two chroma rows by phase.
// ----------------------------------------------------------------------------
module cus_row_weight
    import cus_pkg::*;
(
    input  logic [SAMPLE_W-1:0] i_top,
    input  logic [SAMPLE_W-1:0] i_bottom,
    input  t_vmode              i_mode,
    output logic [SAMPLE_W-1:0] o_sample
);

    logic [SAMPLE_W+1:0] w_top;
    logic [SAMPLE_W+1:0] w_bot;
    logic [SAMPLE_W+1:0] w_sum;

    assign w_top = {2'b00, i_top};
    assign w_bot = {2'b00, i_bottom};

    always_comb begin
        w_sum = w_top;
        case (i_mode)
            VW_TOP:     w_sum = {w_top[SAMPLE_W-1:0], 2'b00};
            VW_HALF:    w_sum = (w_top + w_bot + 14'd1) << 1;
            VW_QUARTER: w_sum = (w_top << 1) + w_top + w_bot + 14'd2;
            VW_3QUART:  w_sum = w_top + (w_bot << 1) + w_bot + 14'd2;
            default:    w_sum = {w_top[SAMPLE_W-1:0], 2'b00};
        endcase
    end

    // every mode leaves the result in bits [13:2]
    assign o_sample = w_sum[SAMPLE_W+1:2];

endmodule

/* src/chroma_upsample_yuv_to_rgb.sv */
// ----------------------------------------------------------------------------
// chroma_upsample_yuv_to_rgb
// Chroma upsampling and 8-bit RGB conversion, five register stages.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle; the five-stage pipe with per-stage valid
//   bits absorbs bubbles, and a stalled output holds the pipe only when full.
// Reset (synchronous, active low) empties the pipe and loads the registers:
//   depth 8, horizontal and vertical subsampling on, vertical siting off.
// Configuration writes are taken every cycle.
module chroma_upsample_yuv_to_rgb
    import cus_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DEPTH_W-1:0]   i_cfg_data,
    // pixel items in
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [COORD_W-1:0]   i_pixel_x,
    input  logic [COORD_W-1:0]   i_pixel_y,
    input  logic [SAMPLE_W-1:0]  i_luma_sample,
    input  logic [SAMPLE_W-1:0]  i_cb_top_left,
    input  logic [SAMPLE_W-1:0]  i_cb_bottom_left,
    input  logic [SAMPLE_W-1:0]  i_cb_top_right,
    input  logic [SAMPLE_W-1:0]  i_cb_bottom_right,
    input  logic [SAMPLE_W-1:0]  i_cr_top_left,
    input  logic [SAMPLE_W-1:0]  i_cr_bottom_left,
    input  logic [SAMPLE_W-1:0]  i_cr_top_right,
    input  logic [SAMPLE_W-1:0]  i_cr_bottom_right,
    // results out
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [SAMPLE_W-1:0]  o_luma_out,
    output logic [SAMPLE_W-1:0]  o_cb_out,
    output logic [SAMPLE_W-1:0]  o_cr_out,
    output logic [BYTE_W-1:0]    o_red,
    output logic [BYTE_W-1:0]    o_green,
    output logic [BYTE_W-1:0]    o_blue
);

    function automatic logic [SCALE_W-1:0] scale_for(logic [DEPTH_W-1:0] depth);
        logic [SCALE_W-1:0] s;
        case (depth) inside
            [4'd0:4'd8]: s = SCALE_8;
            4'd9:        s = SCALE_9;
            4'd10:       s = SCALE_10;
            4'd11:       s = SCALE_11;
            default:     s = SCALE_12;
        endcase
        return s;
    endfunction

    // round half up on 2^-30 units, clamp to 0..255
    function automatic logic [BYTE_W-1:0] to_byte(logic signed [47:0] acc);
        logic signed [47:0] v;
        logic [BYTE_W-1:0]  b;
        v = acc + 48'sd536870912;
        if (v[47]) begin
            b = '0;
        end else if (|v[46:38]) begin
            b = '1;
        end else begin
            b = v[37:30];
        end
        return b;
    endfunction

    // configuration registers
    logic [DEPTH_W-1:0] r_sample_depth;
    logic               r_sub_horiz;
    logic               r_sub_vert;
    logic               r_vert_siting;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_depth <= DEPTH_W'(8);
            r_sub_horiz    <= 1'b1;
            r_sub_vert     <= 1'b1;
            r_vert_siting  <= 1'b0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SAMPLE_DEPTH: r_sample_depth <= i_cfg_data;
                CFG_SUB_HORIZ:    r_sub_horiz    <= i_cfg_data[0];
                CFG_SUB_VERT:     r_sub_vert     <= i_cfg_data[0];
                CFG_VERT_SITING:  r_vert_siting  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // stage handshake: a stage loads when empty or when the next one loads
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy5;

    assign w_rdy5  = !r_v5 || i_ready;
    assign w_rdy4  = !r_v4 || w_rdy5;
    assign w_rdy3  = !r_v3 || w_rdy4;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
            if (w_rdy5) r_v5 <= r_v4;
        end
    end

    // ---- stage 1: vertical phase and row weighting
    t_vmode n_vmode;

    always_comb begin
        if (!r_sub_vert) begin
            n_vmode = VW_TOP;
        end else if (!r_vert_siting) begin
            n_vmode = i_pixel_y[0] ? VW_HALF : VW_TOP;
        end else if (i_pixel_y == '0) begin
            // first row with siting: top row only
            n_vmode = VW_TOP;
        end else begin
            // phase of 2y-1 in quarters: odd rows 1/4, even rows 3/4
            n_vmode = i_pixel_y[0] ? VW_QUARTER : VW_3QUART;
        end
    end

    logic [SAMPLE_W-1:0] n_cb_left, n_cb_right, n_cr_left, n_cr_right;

    cus_row_weight u_cb_left (
        .i_top    (i_cb_top_left),
        .i_bottom (i_cb_bottom_left),
        .i_mode   (n_vmode),
        .o_sample (n_cb_left)
    );

    cus_row_weight u_cb_right (
        .i_top    (i_cb_top_right),
        .i_bottom (i_cb_bottom_right),
        .i_mode   (n_vmode),
        .o_sample (n_cb_right)
    );

    cus_row_weight u_cr_left (
        .i_top    (i_cr_top_left),
        .i_bottom (i_cr_bottom_left),
        .i_mode   (n_vmode),
        .o_sample (n_cr_left)
    );

    cus_row_weight u_cr_right (
        .i_top    (i_cr_top_right),
        .i_bottom (i_cr_bottom_right),
        .i_mode   (n_vmode),
        .o_sample (n_cr_right)
    );

    logic [SAMPLE_W-1:0] r_luma1, r_cbl1, r_cbr1, r_crl1, r_crr1;
    logic                r_odd1;

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r_luma1 <= i_luma_sample;
            r_cbl1  <= n_cb_left;
            r_cbr1  <= n_cb_right;
            r_crl1  <= n_cr_left;
            r_crr1  <= n_cr_right;
            r_odd1  <= i_pixel_x[0] & r_sub_horiz;
        end
    end

    // ---- stage 2: horizontal average on odd columns when horizontal subsampling is on
    logic [SAMPLE_W:0]   n_cb_sum, n_cr_sum;
    logic [SAMPLE_W-1:0] r_luma2, r_cb2, r_cr2;

    assign n_cb_sum = {1'b0, r_cbl1} + {1'b0, r_cbr1} + 13'd1;
    assign n_cr_sum = {1'b0, r_crl1} + {1'b0, r_crr1} + 13'd1;

    always_ff @(posedge i_clk) begin
        if (w_rdy2 && r_v1) begin
            r_luma2 <= r_luma1;
            r_cb2   <= r_odd1 ? n_cb_sum[SAMPLE_W:1] : r_cbl1;
            r_cr2   <= r_odd1 ? n_cr_sum[SAMPLE_W:1] : r_crl1;
        end
    end

    // ---- stage 3: normalize to Q8.16 and center chroma
    logic [SCALE_W-1:0]   w_scale;
    logic [28:0]          n_yn, n_un_raw, n_vn_raw;
    logic [SAMPLE_W-1:0]  r_luma3, r_cb3, r_cr3;
    logic [28:0]          r_yn3;
    logic signed [29:0]   r_un3, r_vn3;

    assign w_scale  = scale_for(r_sample_depth);
    assign n_yn     = 29'({17'd0, r_luma2} * {12'd0, w_scale});
    assign n_un_raw = 29'({17'd0, r_cb2} * {12'd0, w_scale});
    assign n_vn_raw = 29'({17'd0, r_cr2} * {12'd0, w_scale});

    always_ff @(posedge i_clk) begin
        if (w_rdy3 && r_v2) begin
            r_luma3 <= r_luma2;
            r_cb3   <= r_cb2;
            r_cr3   <= r_cr2;
            r_yn3   <= n_yn;
            r_un3   <= $signed({1'b0, n_un_raw}) - HALF_OFFSET;
            r_vn3   <= $signed({1'b0, n_vn_raw}) - HALF_OFFSET;
        end
    end

    // ---- stage 4: matrix products, 2^-30 units
    logic signed [47:0] n_prv, n_pgu, n_pgv, n_pbu;
    logic [SAMPLE_W-1:0] r_luma4, r_cb4, r_cr4;
    logic signed [47:0] r_yb4, r_prv4, r_pgu4, r_pgv4, r_pbu4;

    // operands sign-extended; the products are 30 by 18 bits
    assign n_prv = 48'(r_vn3) * 48'(COEF_RV);
    assign n_pgu = 48'(r_un3) * 48'(COEF_GU);
    assign n_pgv = 48'(r_vn3) * 48'(COEF_GV);
    assign n_pbu = 48'(r_un3) * 48'(COEF_BU);

    always_ff @(posedge i_clk) begin
        if (w_rdy4 && r_v3) begin
            r_luma4 <= r_luma3;
            r_cb4   <= r_cb3;
            r_cr4   <= r_cr3;
            r_yb4   <= $signed({5'd0, r_yn3, 14'd0});
            r_prv4  <= n_prv;
            r_pgu4  <= n_pgu;
            r_pgv4  <= n_pgv;
            r_pbu4  <= n_pbu;
        end
    end

    // ---- stage 5: sums, rounding, saturation into the output register
    logic signed [47:0] n_acc_r, n_acc_g, n_acc_b;
    logic [SAMPLE_W-1:0] r_luma5, r_cb5, r_cr5;
    logic [BYTE_W-1:0]   r_red5, r_green5, r_blue5;

    assign n_acc_r = r_yb4 + r_prv4;
    assign n_acc_g = r_yb4 - r_pgu4 - r_pgv4;
    assign n_acc_b = r_yb4 + r_pbu4;

    always_ff @(posedge i_clk) begin
        if (w_rdy5 && r_v4) begin
            r_luma5  <= r_luma4;
            r_cb5    <= r_cb4;
            r_cr5    <= r_cr4;
            r_red5   <= to_byte(n_acc_r);
            r_green5 <= to_byte(n_acc_g);
            r_blue5  <= to_byte(n_acc_b);
        end
    end

    assign o_valid    = r_v5;
    assign o_luma_out = r_luma5;
    assign o_cb_out   = r_cb5;
    assign o_cr_out   = r_cr5;
    assign o_red      = r_red5;
    assign o_green    = r_green5;
    assign o_blue     = r_blue5;

endmodule

/* src/cus_checker.sv */
// ----------------------------------------------------------------------------
// cus_checker
// Port-level checks for chroma_upsample_yuv_to_rgb, bound to the top level.
// ----------------------------------------------------------------------------
`include "chroma_upsample_yuv_to_rgb_macros.svh"

module cus_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_cfg_ready,
    input logic [11:0] o_luma_out,
    input logic [11:0] o_cb_out,
    input logic [11:0] o_cr_out,
    input logic [7:0]  o_red,
    input logic [7:0]  o_green,
    input logic [7:0]  o_blue
);

    // a blocked result item holds its payload
    `CUS_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_luma_out) && $stable(o_cb_out) && $stable(o_cr_out) && $stable(o_red) && $stable(o_green) && $stable(o_blue), "result item changed while stalled")

    // input stalls only when the output holds a valid item and is blocked
    `CUS_ASSERT(a_stall_full, i_clk, i_rst_n, !o_ready |-> o_valid && !i_ready, "input stalled with room in the pipe")

    // reset empties the pipe
    `CUS_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_valid && o_ready, "pipe not empty after reset")

    // configuration port never back-pressures
    `CUS_ASSERT(a_cfg_ready, i_clk, i_rst_n, o_cfg_ready, "config port not ready")

endmodule

bind chroma_upsample_yuv_to_rgb cus_checker u_cus_checker (.*);
